// File: rtl/dtq_pkg.sv
// Package: shared types, command and status codes for the deadline timer queue.
package dtq_pkg;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_INSERT  = 2'd1;
  localparam logic [1:0] CMD_DELETE  = 2'd2;
  localparam logic [1:0] CMD_SERVICE = 2'd3;

  localparam logic [2:0] ST_TICKED   = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_EXPIRED  = 3'd5;
  localparam logic [2:0] ST_NONE     = 3'd6;

  localparam int MaxResults = 16;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] amount;
    logic [7:0]  handle;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_handle;
    logic       work_pending;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic       load_in;
    logic       adv_clock;
    logic       scan_start;
    logic       insert;
    logic       delete_hit;
    logic       flag_tick;
    logic       flag_service;
    logic       emit_clear;
    logic       out_load;
    logic [2:0] out_status;
    logic       out_last;
  } ctl_t;

  typedef struct packed {
    logic       scan_done;
    logic       found;
    logic       full;
    logic       cnt_zero;
    logic       emit_last;
    logic       out_free;
  } sts_t;

endpackage

// File: rtl/dtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dtq_datapath.sv
// Datapath: clock, slot stores, sequential slot scan and result register.
module dtq_datapath #(
  parameter int CAPACITY    = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  dtq_pkg::req_t req,
  input  logic          rsp_stall,
  output logic          rsp_valid,
  output dtq_pkg::rsp_t rsp,
  input  dtq_pkg::ctl_t ctl,
  output dtq_pkg::sts_t sts
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = $clog2(dtq_pkg::MaxResults + 1);
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

  logic [63:0]            now;
  logic [CAPACITY-1:0]    valid;
  logic                   flag;
  logic [31:0]            amount;
  logic [HANDLE_BITS-1:0] hnd;

  logic [IW-1:0]          sc_idx;
  logic                   sc_act;
  logic                   d_v;
  logic [IW-1:0]          pidx;

  logic [CW-1:0]          cnt;
  logic                   found;
  logic [IW-1:0]          fidx;
  logic                   bfound;
  logic [63:0]            bdl;
  logic [IW-1:0]          bidx;
  logic [HANDLE_BITS-1:0] bhd;

  logic [EW-1:0]          total;
  logic [EW-1:0]          emitted;

  logic [63:0]            rd_dl;
  logic [HANDLE_BITS-1:0] rd_hd;
  logic [IW-1:0]          free_idx;
  logic                   full;
  logic                   hit_exp;
  logic                   hit_match;
  logic                   flag_next;
  logic                   ins_we;

  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign full   = &valid;
  assign ins_we = ctl.insert && !full;

  dtq_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_dl_ram (
    .clk   (clk),
    .we    (ins_we),
    .waddr (free_idx),
    .wdata (now + 64'(amount)),
    .raddr (sc_idx),
    .rdata (rd_dl)
  );

  dtq_ram #(.WIDTH(HANDLE_BITS), .DEPTH(CAPACITY)) u_hd_ram (
    .clk   (clk),
    .we    (ins_we),
    .waddr (free_idx),
    .wdata (hnd),
    .raddr (sc_idx),
    .rdata (rd_hd)
  );

  assign hit_exp   = d_v && valid[pidx] && (rd_dl < now);
  assign hit_match = d_v && valid[pidx] && (rd_hd == hnd);

  always_comb begin
    flag_next = flag;
    if (ctl.flag_tick && cnt != '0) begin
      flag_next = 1'b1;
    end
    if (ctl.flag_service) begin
      flag_next = 32'(cnt) > dtq_pkg::MaxResults;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      amount <= req.amount;
      hnd    <= HANDLE_BITS'(req.handle);
    end
    if (ctl.scan_start) begin
      sc_idx <= '0;
    end else if (sc_act) begin
      sc_idx <= sc_idx + 1'b1;
    end
    pidx <= sc_idx;
    if (ctl.scan_start) begin
      cnt    <= '0;
      found  <= 1'b0;
      bfound <= 1'b0;
    end else begin
      if (hit_exp) begin
        cnt <= cnt + 1'b1;
      end
      if (hit_match && !found) begin
        found <= 1'b1;
        fidx  <= pidx;
      end
      if (hit_exp && (!bfound || rd_dl < bdl)) begin
        bfound <= 1'b1;
        bdl    <= rd_dl;
        bidx   <= pidx;
        bhd    <= rd_hd;
      end
    end
    if (ctl.flag_service) begin
      total   <= (32'(cnt) > dtq_pkg::MaxResults) ? EW'(dtq_pkg::MaxResults) : EW'(cnt);
      emitted <= '0;
    end else if (ctl.emit_clear) begin
      emitted <= emitted + 1'b1;
    end
    if (ctl.out_load) begin
      rsp.status       <= ctl.out_status;
      rsp.out_handle   <= (ctl.out_status == dtq_pkg::ST_EXPIRED) ? 8'(bhd) : 8'd0;
      rsp.work_pending <= flag_next;
      rsp.last         <= ctl.out_last;
    end
    if (rst) begin
      now       <= '0;
      valid     <= '0;
      flag      <= 1'b0;
      sc_act    <= 1'b0;
      d_v       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.adv_clock) begin
        now <= now + 64'(amount);
      end
      if (ins_we) begin
        valid[free_idx] <= 1'b1;
      end
      if (ctl.delete_hit && found) begin
        valid[fidx] <= 1'b0;
      end
      if (ctl.emit_clear) begin
        valid[bidx] <= 1'b0;
      end
      flag <= flag_next;
      if (ctl.scan_start) begin
        sc_act <= 1'b1;
      end else if (sc_act && sc_idx == LastIdx) begin
        sc_act <= 1'b0;
      end
      d_v <= sc_act && !ctl.scan_start;
      if (ctl.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign sts.scan_done = d_v && pidx == LastIdx;
  assign sts.found     = found;
  assign sts.full      = full;
  assign sts.cnt_zero  = cnt == '0;
  assign sts.emit_last = (emitted + 1'b1) == total;
  assign sts.out_free  = !rsp_valid || !rsp_stall;

endmodule

// File: rtl/dtq_ctrl.sv
// Controller: sequences tick, insert, delete and service transactions.
module dtq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dtq_pkg::req_t req,
  input  dtq_pkg::sts_t sts,
  output dtq_pkg::ctl_t ctl
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ADV       = 4'd1;
  localparam logic [3:0] S_TICK_WAIT = 4'd2;
  localparam logic [3:0] S_TICK_OUT  = 4'd3;
  localparam logic [3:0] S_INS       = 4'd4;
  localparam logic [3:0] S_DEL_WAIT  = 4'd5;
  localparam logic [3:0] S_DEL_OUT   = 4'd6;
  localparam logic [3:0] S_CNT_WAIT  = 4'd7;
  localparam logic [3:0] S_DECIDE    = 4'd8;
  localparam logic [3:0] S_NONE      = 4'd9;
  localparam logic [3:0] S_EMIT_WAIT = 4'd10;
  localparam logic [3:0] S_EMIT      = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_stall = state != S_IDLE;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.load_in = 1'b1;
          case (req.cmd)
            dtq_pkg::CMD_TICK:   state_next = S_ADV;
            dtq_pkg::CMD_INSERT: state_next = S_INS;
            dtq_pkg::CMD_DELETE: begin
              ctl.scan_start = 1'b1;
              state_next     = S_DEL_WAIT;
            end
            default: begin
              ctl.scan_start = 1'b1;
              state_next     = S_CNT_WAIT;
            end
          endcase
        end
      end
      S_ADV: begin
        ctl.adv_clock  = 1'b1;
        ctl.scan_start = 1'b1;
        state_next     = S_TICK_WAIT;
      end
      S_TICK_WAIT: if (sts.scan_done) state_next = S_TICK_OUT;
      S_TICK_OUT: begin
        if (sts.out_free) begin
          ctl.flag_tick  = 1'b1;
          ctl.out_load   = 1'b1;
          ctl.out_status = dtq_pkg::ST_TICKED;
          ctl.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_INS: begin
        if (sts.out_free) begin
          ctl.insert     = 1'b1;
          ctl.out_load   = 1'b1;
          ctl.out_status = sts.full ? dtq_pkg::ST_FULL : dtq_pkg::ST_INSERTED;
          ctl.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_DEL_WAIT: if (sts.scan_done) state_next = S_DEL_OUT;
      S_DEL_OUT: begin
        if (sts.out_free) begin
          ctl.delete_hit = 1'b1;
          ctl.out_load   = 1'b1;
          ctl.out_status = sts.found ? dtq_pkg::ST_DELETED : dtq_pkg::ST_NOTFOUND;
          ctl.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_CNT_WAIT: if (sts.scan_done) state_next = S_DECIDE;
      S_DECIDE: begin
        ctl.flag_service = 1'b1;
        if (sts.cnt_zero) begin
          state_next = S_NONE;
        end else begin
          ctl.scan_start = 1'b1;
          state_next     = S_EMIT_WAIT;
        end
      end
      S_NONE: begin
        if (sts.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_status = dtq_pkg::ST_NONE;
          ctl.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_EMIT_WAIT: if (sts.scan_done) state_next = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.emit_clear = 1'b1;
          ctl.out_load   = 1'b1;
          ctl.out_status = dtq_pkg::ST_EXPIRED;
          ctl.out_last   = sts.emit_last;
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end else begin
            ctl.scan_start = 1'b1;
            state_next     = S_EMIT_WAIT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/deadline_timer_queue_core.sv
// Top level: deadline timer queue, controller plus datapath.
//
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req (cmd, amount, handle)
//  result  | rsp_valid | rsp_stall | rsp (status, out_handle, work_pending, last)
//
// Insert needs no scan. Delete scans one slot per cycle through the
// deadline/handle RAM read port. Tick advances the clock first, then scans.
// Service runs a counting scan, then one scan per expired entry (at most MaxResults),
// or gives a none result when none expired. A stalled result delays the transaction.
// Synchronous reset empties the store and clears clock and flag at once.
// A request is taken only when idle; a stalled result holds further results.
module deadline_timer_queue_core #(
  parameter int CAPACITY    = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dtq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dtq_pkg::rsp_t rsp
);

  dtq_pkg::ctl_t ctl;
  dtq_pkg::sts_t sts;

  dtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .sts       (sts),
    .ctl       (ctl)
  );

  dtq_datapath #(.CAPACITY(CAPACITY), .HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule
